FILE: sv/rzpg_pkg.sv
// Package for the rectangle zone pan gain core: payload structs, register codes,
// fixed widths and the per-axis operand setup function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rzpg_pkg;

	localparam int COORD_BITS     = 16;
	localparam int GAIN_FRAC_BITS = 15;
	localparam int SIZE_BITS      = 15;
	localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
	localparam int NUM_BITS       = GAIN_BITS + SIZE_BITS + 1;
	localparam int CFG_ADDR_BITS  = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_RECT_LEFT   = 3'd0,
		REG_RECT_TOP    = 3'd1,
		REG_RECT_WIDTH  = 3'd2,
		REG_RECT_HEIGHT = 3'd3,
		REG_FADE_WIDTH  = 3'd4,
		REG_STEREO_PAN  = 3'd5
	} reg_code_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] src_x;
		logic signed [COORD_BITS-1:0] src_y;
	} src_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0] left_gain;
		logic [GAIN_BITS-1:0] right_gain;
	} gain_t;

	// Numerator is p*q + r*u, divided (rounded) by den.
	typedef struct packed {
		logic [GAIN_BITS-1:0] p;
		logic [SIZE_BITS-1:0] q;
		logic [GAIN_BITS-1:0] r;
		logic [SIZE_BITS-1:0] u;
		logic [SIZE_BITS-1:0] den;
	} axis_op_t;

	// Sets up the window division for one axis: t is the local coordinate,
	// s the size, f the fade width, a and b the values at both edges.
	function automatic axis_op_t axis_setup(logic signed [COORD_BITS:0] t,
		logic [SIZE_BITS-1:0] s, logic [SIZE_BITS-1:0] f,
		logic [GAIN_BITS-1:0] a, logic [GAIN_BITS-1:0] b);
		axis_op_t op;
		logic signed [COORD_BITS+1:0] te, fe, se, d;
		te = {t[COORD_BITS], t};
		fe = {3'b000, f};
		se = {3'b000, s};
		op = '0;
		op.den = SIZE_BITS'(1);
		if (te < -fe || te > se + fe) begin
			op.p = '0;
		end else if (te < 0) begin
			d = te + fe;
			op.p = a;
			op.q = d[SIZE_BITS-1:0];
			op.den = f;
		end else if (te > se) begin
			d = se + fe - te;
			op.p = b;
			op.q = d[SIZE_BITS-1:0];
			op.den = f;
		end else if (s == '0) begin
			op.p = a;
			op.q = SIZE_BITS'(1);
		end else begin
			d = se - te;
			op.p = a;
			op.q = d[SIZE_BITS-1:0];
			op.r = b;
			op.u = te[SIZE_BITS-1:0];
			op.den = s;
		end
		return op;
	endfunction

endpackage
`default_nettype wire

FILE: sv/rect_zone_pan_gain_core.sv
// Rectangle zone pan gain core: source position in, left and right Q1.15 gains out.
// Depends on rzpg_pkg for payload structs, register codes and axis setup.
`timescale 1ns / 1ps
`default_nettype none
// start travels through stages 1 to 4, the divider, the product and output stages to done.
// Throughput: one transaction per cycle; busy is always low, since the
// receiver cannot stall and every stage advances each cycle.
// The depth is set by the three 16-stage rounding dividers, one quotient bit each.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register
// reset values; payload registers are not reset.
module rect_zone_pan_gain_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  rzpg_pkg::src_t                    src,
	output logic                              done,
	output rzpg_pkg::gain_t                   result,
	input  wire                               cfg_we,
	input  wire [rzpg_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire [rzpg_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int CB = rzpg_pkg::COORD_BITS;
	localparam int SB = rzpg_pkg::SIZE_BITS;
	localparam int GB = rzpg_pkg::GAIN_BITS;
	localparam int NB = rzpg_pkg::NUM_BITS;
	localparam int QB = GB;
	localparam int NDIV = 3;  // 0: vertical, 1: left, 2: right

	// Configuration registers. The user must change them only while the pipeline is empty; the block
	// itself does not enforce it, and stages 1 and 2 read them directly.
	logic signed [CB-1:0] rect_left_q, rect_top_q;
	logic [SB-1:0] rect_width_q, rect_height_q, fade_width_q;
	logic [GB-1:0] stereo_pan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_top_q    <= '0;
			rect_width_q  <= SB'(1024);
			rect_height_q <= SB'(1024);
			fade_width_q  <= SB'(64);
			stereo_pan_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rzpg_pkg::REG_RECT_LEFT:   rect_left_q   <= cfg_wdata;
				rzpg_pkg::REG_RECT_TOP:    rect_top_q    <= cfg_wdata;
				rzpg_pkg::REG_RECT_WIDTH:  rect_width_q  <= cfg_wdata[SB-1:0];
				rzpg_pkg::REG_RECT_HEIGHT: rect_height_q <= cfg_wdata[SB-1:0];
				rzpg_pkg::REG_FADE_WIDTH:  fade_width_q  <= cfg_wdata[SB-1:0];
				rzpg_pkg::REG_STEREO_PAN:  stereo_pan_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Pan is saturated to unity; the far side of the slope gets unity minus pan.
	logic [GB-1:0] far_gain;
	assign far_gain = rzpg_pkg::UNITY -
		((stereo_pan_q > rzpg_pkg::UNITY) ? rzpg_pkg::UNITY : stereo_pan_q);

	// Stage 1: local coordinates relative to the rectangle edges.
	logic v_s1;
	logic signed [CB:0] tx_s1, ty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		tx_s1 <= (CB+1)'(src.src_x) - (CB+1)'(rect_left_q);
		ty_s1 <= (CB+1)'(src.src_y) - (CB+1)'(rect_top_q);
	end

	// Stage 2: window segment selection and multiplier operands.
	logic v_s2;
	rzpg_pkg::axis_op_t op_s2 [NDIV];
	logic [GB-1:0] la, lb;

	// A rectangle narrower than two units puts both speakers on the right slope.
	always_comb begin
		if (rect_width_q >= SB'(2)) begin
			la = rzpg_pkg::UNITY;
			lb = far_gain;
		end else begin
			la = far_gain;
			lb = rzpg_pkg::UNITY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		op_s2[0] <= rzpg_pkg::axis_setup(ty_s1, rect_height_q, fade_width_q,
			rzpg_pkg::UNITY, rzpg_pkg::UNITY);
		op_s2[1] <= rzpg_pkg::axis_setup(tx_s1, rect_width_q, fade_width_q, la, lb);
		op_s2[2] <= rzpg_pkg::axis_setup(tx_s1, rect_width_q, fade_width_q,
			far_gain, rzpg_pkg::UNITY);
	end

	// Stage 3: the two weight products of each window.
	logic v_s3;
	logic [NB-2:0] pa_s3 [NDIV];
	logic [NB-2:0] pb_s3 [NDIV];
	logic [SB-1:0] den_s3 [NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	// Stage 4: numerator with half the divisor added for round-to-nearest.
	logic v_s4;
	logic [NB-1:0] num_s4 [NDIV];
	logic [SB-1:0] den_s4 [NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	for (genvar g = 0; g < NDIV; g++) begin : g_prod
		always_ff @(posedge clk) begin
			pa_s3[g]  <= (NB-1)'(op_s2[g].p) * (NB-1)'(op_s2[g].q);
			pb_s3[g]  <= (NB-1)'(op_s2[g].r) * (NB-1)'(op_s2[g].u);
			den_s3[g] <= op_s2[g].den;
			num_s4[g] <= NB'(pa_s3[g]) + NB'(pb_s3[g]) + NB'(den_s3[g] >> 1);
			den_s4[g] <= den_s3[g];
		end
	end

	// Divider: one restoring stage per quotient bit, most significant first.
	// Index 0 of these arrays is the stage 4 output.
	logic          dv  [QB+1];
	logic [NB-1:0] rem [QB+1][NDIV];
	logic [SB-1:0] dd  [QB+1][NDIV];
	logic [QB-1:0] quo [QB+1][NDIV];

	assign dv[0] = v_s4;

	for (genvar g = 0; g < NDIV; g++) begin : g_div_in
		assign rem[0][g] = num_s4[g];
		assign dd[0][g]  = den_s4[g];
		assign quo[0][g] = '0;
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else dv[k+1] <= dv[k];
		end
		for (genvar g = 0; g < NDIV; g++) begin : g_lane
			logic [NB-1:0] sh;
			assign sh = NB'(dd[k][g]) << (QB-1-k);
			always_ff @(posedge clk) begin
				dd[k+1][g] <= dd[k][g];
				if (rem[k][g] >= sh) begin
					rem[k+1][g] <= rem[k][g] - sh;
					quo[k+1][g] <= quo[k][g] | (QB'(1) << (QB-1-k));
				end else begin
					rem[k+1][g] <= rem[k][g];
					quo[k+1][g] <= quo[k][g];
				end
			end
		end
	end

	// Product stage: horizontal window times vertical window.
	logic v_m;
	logic [2*GB-1:0] pl_m, pr_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else v_m <= dv[QB];
	end

	always_ff @(posedge clk) begin
		pl_m <= (2*GB)'(quo[QB][1]) * (2*GB)'(quo[QB][0]);
		pr_m <= (2*GB)'(quo[QB][2]) * (2*GB)'(quo[QB][0]);
	end

	// Output stage: round back to Q1.15 and raise the strobe for one cycle.
	localparam logic [2*GB-1:0] HALF = (2*GB)'(1) << (rzpg_pkg::GAIN_FRAC_BITS - 1);
	logic [2*GB-1:0] rl, rr;
	assign rl = (pl_m + HALF) >> rzpg_pkg::GAIN_FRAC_BITS;
	assign rr = (pr_m + HALF) >> rzpg_pkg::GAIN_FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_m;
	end

	always_ff @(posedge clk) begin
		result.left_gain  <= rl[GB-1:0];
		result.right_gain <= rr[GB-1:0];
	end

endmodule
`default_nettype wire
